### src/dead_reckoning_odometry_defines.svh
// Assertion macros shared by the odometry checker.
`ifndef DEAD_RECKONING_ODOMETRY_DEFINES_SVH
`define DEAD_RECKONING_ODOMETRY_DEFINES_SVH

// Concurrent assertion on the rising clock edge, switched off while rst is high.
`define DRO_ASSERT_RST(label, rst, prop, msg) \
   label: assert property (@(posedge clock) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds through reset.
`define DRO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/dro_pkg.sv
// Package with the widths, constants and sine table of the odometry integrator.
package dro_pkg;

   // Field widths.
   localparam int DIST_W = 16;
   localparam int ANG_W  = 16;
   localparam int HDG_W  = 9;
   localparam int POS_W  = 48;

   // Fraction bits of the cosine and sine values.
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_MAG_W     = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int PROD_W         = DIST_W + TRIG_W;
   // A scaled step never exceeds 2^31 in magnitude.
   localparam int STEP_W         = 33;

   // Angles in whole degrees.
   localparam int FULL_TURN    = 360;
   localparam int HALF_TURN    = 180;
   localparam int QUARTER_TURN = 90;
   localparam int SIN_DEPTH    = QUARTER_TURN + 1;
   localparam int SIN_IDX_W    = $clog2(SIN_DEPTH);
   localparam int ABS_HDG_W    = HDG_W - 1;

   // Reduction of the heading change modulo a full turn. The change is biased
   // by a multiple of 360 so that it is never negative, and the quotient is
   // taken by a reciprocal multiply that is exact for every biased value.
   localparam int MOD_BIAS  = 92 * FULL_TURN;
   localparam int MOD_W     = ANG_W + 1;
   localparam int MOD_SHIFT = 25;
   localparam int MOD_RECIP = ((1 << MOD_SHIFT) + FULL_TURN - 1) / FULL_TURN;
   localparam int QUOT_W    = 8;
   localparam int REM_W     = 9;
   localparam int WRAP_W    = HDG_W + 2;

   // Saturation limits of the position accumulators.
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   // Pi in Q2.30 and the divisors of the Taylor series terms.
   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam int Q30_SHIFT = 30;
   localparam int TRIG_SHIFT = Q30_SHIFT - TRIG_FRAC_BITS;
   localparam int SERIES_TERMS = 6;
   localparam int unsigned TERM_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156};

   typedef logic [TRIG_MAG_W-1:0] trig_table_type [SIN_DEPTH];

   // Load enables of the two heading stages.
   typedef struct packed {
      logic quot;
      logic wrap;
   } dro_hdg_load_type;

   // Load enables of the three accumulation stages.
   typedef struct packed {
      logic prod;
      logic step;
      logic pos;
   } dro_acc_load_type;

   // Quarter-wave sine, one entry per degree, built at elaboration from a
   // thirteenth-order series in Q2.30 and rounded half up.
   function automatic trig_table_type build_sin_table();
      trig_table_type tbl;
      logic [63:0]    t;
      logic [63:0]    u;
      logic [63:0]    term;
      logic [63:0]    r;
      longint         acc;
      for (int k = 0; k < SIN_DEPTH; k++) begin
         t    = (64'(k) * PI_Q30) / 64'(HALF_TURN);
         u    = (t * t) >> Q30_SHIFT;
         term = t;
         acc  = longint'(t);
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * u) >> Q30_SHIFT) / 64'(TERM_DIV[n-1]);
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         r = (64'(acc) + (64'd1 << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
         if (r > (64'd1 << TRIG_FRAC_BITS)) begin
            r = 64'd1 << TRIG_FRAC_BITS;
         end
         tbl[k] = TRIG_MAG_W'(r);
      end
      return tbl;
   endfunction

   localparam trig_table_type SIN_TABLE = build_sin_table();

endpackage

### src/dro_heading.sv
// Heading stages: modulo reduction of the change and the wrapped heading state.
module dro_heading (
   input  logic                                clock,
   input  logic                                reset,
   input  dro_pkg::dro_hdg_load_type           load,
   input  logic signed [dro_pkg::DIST_W-1:0]   travel,
   input  logic signed [dro_pkg::ANG_W-1:0]    ang,
   output logic signed [dro_pkg::DIST_W-1:0]   dist_out,
   output logic signed [dro_pkg::HDG_W-1:0]    heading
);
   import dro_pkg::*;

   logic [MOD_W-1:0]              biased;
   logic [2*MOD_W-1:0]            quot_prod;
   logic [MOD_W-1:0]              u_ff;
   logic [QUOT_W-1:0]             quot_ff, quot_in;
   logic signed [DIST_W-1:0]      dist_s1_ff, dist_s2_ff;
   logic [REM_W-1:0]              rem;
   logic signed [WRAP_W-1:0]      sum;
   logic signed [HDG_W-1:0]       heading_ff, heading_in;

   // The quotient of the biased change by a full turn.
   always_comb begin
      biased    = MOD_W'({ang[ANG_W-1], ang}) + MOD_W'(MOD_BIAS);
      quot_prod = (2*MOD_W)'(biased) * (2*MOD_W)'(MOD_RECIP);
      quot_in   = QUOT_W'(quot_prod >> MOD_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (load.quot) begin
         u_ff       <= biased;
         quot_ff    <= quot_in;
         dist_s1_ff <= travel;
      end
   end

   // The remainder lies in 0..359, so one correction brings the sum into range.
   always_comb begin
      rem = REM_W'(u_ff - MOD_W'(MOD_W'(quot_ff) * MOD_W'(FULL_TURN)));
      sum = WRAP_W'(heading_ff) + WRAP_W'({1'b0, rem});
      if (sum > WRAP_W'(HALF_TURN)) begin
         sum = sum - WRAP_W'(FULL_TURN);
      end
      heading_in = HDG_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
      end else if (load.wrap) begin
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.wrap) begin
         dist_s2_ff <= dist_s1_ff;
      end
   end

   assign dist_out = dist_s2_ff;
   assign heading  = heading_ff;

endmodule

### src/dro_trig.sv
// Cosine and sine of the heading by quadrant folding of the sine table.
module dro_trig (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [dro_pkg::DIST_W-1:0]   travel,
   input  logic signed [dro_pkg::HDG_W-1:0]    heading,
   output logic signed [dro_pkg::DIST_W-1:0]   dist_out,
   output logic signed [dro_pkg::HDG_W-1:0]    heading_out,
   output logic signed [dro_pkg::TRIG_W-1:0]   cos_out,
   output logic signed [dro_pkg::TRIG_W-1:0]   sin_out
);
   import dro_pkg::*;

   logic [ABS_HDG_W-1:0]         mag;
   logic [SIN_IDX_W-1:0]         cos_idx, sin_idx;
   logic                         cos_neg;
   logic signed [TRIG_W-1:0]     cos_val, sin_val;
   logic signed [TRIG_W-1:0]     cos_in, sin_in;
   logic signed [TRIG_W-1:0]     cos_ff, sin_ff;
   logic signed [DIST_W-1:0]     dist_ff;
   logic signed [HDG_W-1:0]      heading_ff;

   always_comb begin
      mag = ABS_HDG_W'(heading[HDG_W-1] ? -heading : heading);
      if (mag <= ABS_HDG_W'(QUARTER_TURN)) begin
         cos_idx = SIN_IDX_W'(ABS_HDG_W'(QUARTER_TURN) - mag);
         sin_idx = SIN_IDX_W'(mag);
         cos_neg = 1'b0;
      end else begin
         cos_idx = SIN_IDX_W'(mag - ABS_HDG_W'(QUARTER_TURN));
         sin_idx = SIN_IDX_W'(ABS_HDG_W'(HALF_TURN) - mag);
         cos_neg = 1'b1;
      end
      cos_val = TRIG_W'({1'b0, SIN_TABLE[cos_idx]});
      sin_val = TRIG_W'({1'b0, SIN_TABLE[sin_idx]});
      cos_in  = cos_neg ? -cos_val : cos_val;
      sin_in  = heading[HDG_W-1] ? -sin_val : sin_val;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         dist_ff    <= travel;
         heading_ff <= heading;
      end
   end

   assign cos_out     = cos_ff;
   assign sin_out     = sin_ff;
   assign dist_out    = dist_ff;
   assign heading_out = heading_ff;

endmodule

### src/dro_accum.sv
// Accumulation stages: products, rescaling to Q16 and saturating position sums.
module dro_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  dro_pkg::dro_acc_load_type           load,
   input  logic signed [dro_pkg::DIST_W-1:0]   travel,
   input  logic signed [dro_pkg::HDG_W-1:0]    heading,
   input  logic signed [dro_pkg::TRIG_W-1:0]   cos_val,
   input  logic signed [dro_pkg::TRIG_W-1:0]   sin_val,
   output logic signed [dro_pkg::POS_W-1:0]    x_position,
   output logic signed [dro_pkg::POS_W-1:0]    y_position,
   output logic signed [dro_pkg::HDG_W-1:0]    heading_deg
);
   import dro_pkg::*;

   localparam int RSH    = (TRIG_FRAC_BITS > 16) ? TRIG_FRAC_BITS - 16 : 0;
   localparam int LSH    = (TRIG_FRAC_BITS < 16) ? 16 - TRIG_FRAC_BITS : 0;
   localparam int RND_SH = (RSH > 0) ? RSH - 1 : 0;
   localparam int RND    = (RSH > 0) ? (1 << RND_SH) : 0;
   // Bias for negative products, so that the floor shift rounds half away
   // from zero on both sides.
   localparam int RND_NEG = (RSH > 0) ? RND - 1 : 0;
   localparam int BIAS_W  = PROD_W + 1;

   logic signed [PROD_W-1:0]   prod_x_ff, prod_y_ff;
   logic signed [STEP_W-1:0]   step_x_ff, step_y_ff, step_x_in, step_y_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [HDG_W-1:0]    hdg_s4_ff, hdg_s5_ff, hdg_out_ff;

   function automatic logic signed [STEP_W-1:0] rescale(input logic signed [PROD_W-1:0] p);
      logic signed [BIAS_W-1:0] biased;
      biased = BIAS_W'(p) + (p[PROD_W-1] ? BIAS_W'(RND_NEG) : BIAS_W'(RND));
      return STEP_W'(biased >>> RSH) <<< LSH;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] a,
                                                      input logic signed [STEP_W-1:0] b);
      logic signed [POS_W:0] s;
      s = (POS_W+1)'(a) + (POS_W+1)'(b);
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? POS_MIN : POS_MAX;
      end
      return POS_W'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (load.prod) begin
         prod_x_ff <= PROD_W'(travel) * PROD_W'(cos_val);
         prod_y_ff <= PROD_W'(travel) * PROD_W'(sin_val);
         hdg_s4_ff <= heading;
      end
   end

   always_comb begin
      step_x_in = rescale(prod_x_ff);
      step_y_in = rescale(prod_y_ff);
   end

   always_ff @(posedge clock) begin
      if (load.step) begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         hdg_s5_ff <= hdg_s4_ff;
      end
   end

   always_comb begin
      pos_x_in = sat_add(pos_x_ff, step_x_ff);
      pos_y_in = sat_add(pos_y_ff, step_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (load.pos) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.pos) begin
         hdg_out_ff <= hdg_s5_ff;
      end
   end

   assign x_position  = pos_x_ff;
   assign y_position  = pos_y_ff;
   assign heading_deg = hdg_out_ff;

endmodule

### src/dead_reckoning_odometry.sv
// Top level of the dead-reckoning odometry integrator.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/stall    distance_delta, angle_delta
//   rsp_      out        rsp_valid/stall    x_position, y_position, heading_deg
//
// The block is a seven-register pipeline and takes one transaction in every
// clock cycle while no stall holds the pipeline. A result passes through the
// chain of input, quotient, heading, table, product, rescale and position
// registers. Each stage moves on when it is empty or the stage after it
// moves, so bubbles close up and a waiting result does not stop requests
// until the pipeline is full. Reset is synchronous and empties every stage,
// clearing the heading to zero degrees and both positions to zero.
module dead_reckoning_odometry (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [dro_pkg::DIST_W-1:0]  req_distance_delta,
   input  logic signed [dro_pkg::ANG_W-1:0]   req_angle_delta,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [dro_pkg::POS_W-1:0]   rsp_x_position,
   output logic signed [dro_pkg::POS_W-1:0]   rsp_y_position,
   output logic signed [dro_pkg::HDG_W-1:0]   rsp_heading_deg
);
   import dro_pkg::*;

   // Stage 0 is the input register, stage 6 the result register.
   localparam int NUM_STAGES = 7;

   logic [NUM_STAGES-1:0]      valid_ff, valid_in;
   logic [NUM_STAGES-1:0]      ready;
   logic [NUM_STAGES-1:0]      load;

   logic signed [DIST_W-1:0]   dist_ff;
   logic signed [ANG_W-1:0]    ang_ff;

   dro_hdg_load_type           hdg_load;
   dro_acc_load_type           acc_load;

   logic signed [DIST_W-1:0]   hdg_dist, trig_dist;
   logic signed [HDG_W-1:0]    hdg_heading, trig_heading;
   logic signed [TRIG_W-1:0]   trig_cos, trig_sin;

   // A stage is ready to take a transaction when it is empty or its own
   // content moves on in the same cycle.
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      load[0]     = ready[0] && req_valid;
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         load[k]     = ready[k] && valid_ff[k-1];
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         dist_ff <= req_distance_delta;
         ang_ff  <= req_angle_delta;
      end
   end

   always_comb begin
      hdg_load.quot = load[1];
      hdg_load.wrap = load[2];
      acc_load.prod = load[4];
      acc_load.step = load[5];
      acc_load.pos  = load[6];
   end

   dro_heading u_heading (
      .clock    (clock),
      .reset    (reset),
      .load     (hdg_load),
      .travel   (dist_ff),
      .ang      (ang_ff),
      .dist_out (hdg_dist),
      .heading  (hdg_heading)
   );

   dro_trig u_trig (
      .clock       (clock),
      .load        (load[3]),
      .travel      (hdg_dist),
      .heading     (hdg_heading),
      .dist_out    (trig_dist),
      .heading_out (trig_heading),
      .cos_out     (trig_cos),
      .sin_out     (trig_sin)
   );

   dro_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .load        (acc_load),
      .travel      (trig_dist),
      .heading     (trig_heading),
      .cos_val     (trig_cos),
      .sin_val     (trig_sin),
      .x_position  (rsp_x_position),
      .y_position  (rsp_y_position),
      .heading_deg (rsp_heading_deg)
   );

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

### src/dro_checker.sv
// Port-level checker for the odometry integrator and its bind statement.
`include "dead_reckoning_odometry_defines.svh"

module dro_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [dro_pkg::POS_W-1:0]   rsp_x_position,
   input logic signed [dro_pkg::POS_W-1:0]   rsp_y_position,
   input logic signed [dro_pkg::HDG_W-1:0]   rsp_heading_deg
);
   import dro_pkg::*;

   property p_heading_range;
      rsp_valid |-> (rsp_heading_deg >= -HDG_W'(HALF_TURN - 1) &&
                     rsp_heading_deg <= HDG_W'(HALF_TURN));
   endproperty

   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_position) &&
                                 $stable(rsp_y_position) && $stable(rsp_heading_deg);
   endproperty

   // The reported heading always lies in the half-open turn.
   `DRO_ASSERT_RST(a_heading_range, reset, p_heading_range, "heading outside -179..180")

   // A stalled result keeps its positions and heading.
   `DRO_ASSERT_RST(a_rsp_hold, reset, p_rsp_hold, "stalled result changed")

   // With no result waiting the pipeline cannot be full.
   `DRO_ASSERT_RST(a_no_false_stall, reset, !rsp_valid |-> !req_stall, "request stalled")

   // Reset empties the pipeline.
   `DRO_ASSERT(a_reset_empty, reset |=> !rsp_valid, "result shown straight after reset")

endmodule

bind dead_reckoning_odometry dro_checker u_dro_checker (.*);
